@@ hdl/fixed_partition_fit_allocator_macros.svh @@
// Assertion macros shared by the allocator RTL
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define FPFA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpfa: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst
`define FPFA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpfa: next-cycle check failed");

`endif

@@ hdl/fpfa_pkg.sv @@
// Package: sizes, codes and shared types of the fit allocator
package fpfa_pkg;

  // Storage sizing
  localparam int NUM_SLOTS  = 16;
  localparam int SIZE_BITS  = 16;
  localparam int SLOT_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int COUNT_BITS = $clog2(NUM_SLOTS + 1);
  localparam int SUM_BITS   = SIZE_BITS + COUNT_BITS;

  // Fixed field widths of the words
  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int SIZE_W   = 16;
  localparam int LEFT_W   = 16;
  localparam int TOTAL_W  = 20;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int POLICY_W   = 2;
  localparam int BCOUNT_W   = 5;
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_COUNT  = 1'b1;
  localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = BCOUNT_W'(16);

  // Function codes of an input word
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_CLEAR   = 2'd1,
    FUNC_REQUEST = 2'd2
  } func_t;

  // Fit policy codes
  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

  // Settings handed from the register block to the datapath
  typedef struct packed {
    logic [POLICY_W-1:0]   policy;
    logic [COUNT_BITS-1:0] lim;
  } cfg_t;

endpackage

@@ hdl/fpfa_if.sv @@
// Valid/ready channel interfaces for request and result words
interface fpfa_req_if;
  import fpfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SLOT_W-1:0] block_slot;
  logic [SIZE_W-1:0] size_value;
  modport source(output valid, func, block_slot, size_value, input ready);
  modport sink(input valid, func, block_slot, size_value, output ready);
endinterface

interface fpfa_rsp_if;
  import fpfa_pkg::*;
  logic               valid;
  logic               ready;
  logic               granted;
  logic [SLOT_W-1:0]  chosen_block;
  logic [LEFT_W-1:0]  leftover;
  logic [TOTAL_W-1:0] unfilled_total;
  modport source(output valid, granted, chosen_block, leftover, unfilled_total,
                 input ready);
  modport sink(input valid, granted, chosen_block, leftover, unfilled_total,
               output ready);
endinterface

@@ hdl/fixed_partition_fit_allocator.sv @@
// Fixed-partition allocator: a word loads a slot size, frees all slots, or
// requests a block by first, best or worst fit among the first block_count
// slots, and every word returns one result carrying grant, slot, leftover and
// the total size of free slots. Block sizes live in a 16-entry RAM with a
// registered read; used bits are flops. Each word is handled in a read
// scan of the RAM that also sums the free sizes, one slot per cycle, over
// the first block_count slots (a count above 16 counts as 16; with no slots
// active the scan is skipped). A result still waiting in the output
// register holds the word at commit until it is taken. The scan length is
// set by the single RAM read port. A new word is taken while the previous
// result still waits in the output register.
// Reading a slot whose size was never loaded gives an unspecified value.
`include "fixed_partition_fit_allocator_macros.svh"

module fixed_partition_fit_allocator (
  input  logic                            clk,
  input  logic                            rst,
  fpfa_req_if.sink                        req,
  fpfa_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fpfa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fpfa_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fpfa_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import fpfa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  cfg_t                  cfg;
  state_t                state;
  logic [FUNC_W-1:0]     func_q;
  logic [SIZE_BITS-1:0]  size_q;
  logic [COUNT_BITS-1:0] issue_idx;
  logic                  chk_valid;
  logic [SLOT_BITS-1:0]  chk_idx;
  logic                  found;
  logic [SLOT_BITS-1:0]  pick_idx;
  logic [SIZE_BITS-1:0]  pick_size;
  logic [SUM_BITS-1:0]   acc;
  logic [NUM_SLOTS-1:0]  used_map;

  logic                  accept;
  logic                  out_free;
  logic                  ram_we;
  logic                  ram_re;
  logic [SLOT_BITS-1:0]  ram_raddr;
  logic [SIZE_BITS-1:0]  ram_rdata;
  logic                  slot_free;
  logic                  fits;
  logic                  take;
  logic                  last_chk;
  logic [SUM_BITS-1:0]   total_after;

  fpfa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // block size store
  fpfa_ram #(.WIDTH(SIZE_BITS), .DEPTH(NUM_SLOTS)) u_sizes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (SLOT_BITS'(req.block_slot)),
    .wdata (SIZE_BITS'(req.size_value)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handshake and RAM control
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign ram_we    = accept && (req.func == FUNC_LOAD) && (32'(req.block_slot) < NUM_SLOTS);
  assign ram_re    = (state == ST_SCAN) && (issue_idx < cfg.lim);
  assign ram_raddr = issue_idx[SLOT_BITS-1:0];

  // per-slot check on returned read data
  assign slot_free = !used_map[chk_idx];
  assign fits      = slot_free && (ram_rdata >= size_q) && (func_q == FUNC_REQUEST);
  assign take      = fits && (!found ||
                     ((cfg.policy == POLICY_BEST)  && (ram_rdata < pick_size)) ||
                     ((cfg.policy == POLICY_WORST) && (ram_rdata > pick_size)));
  assign last_chk  = (COUNT_BITS'(chk_idx) + COUNT_BITS'(1)) == cfg.lim;

  // free total after the grant is taken out
  assign total_after = found ? (acc - SUM_BITS'(pick_size)) : acc;

  // sequencer, scan registers and used bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chk_valid <= 1'b0;
      found     <= 1'b0;
      used_map  <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // commit reloads the output register itself
      if (rsp.valid && rsp.ready && (state != ST_COMMIT)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            func_q    <= req.func;
            size_q    <= SIZE_BITS'(req.size_value);
            issue_idx <= '0;
            chk_valid <= 1'b0;
            found     <= 1'b0;
            pick_idx  <= '0;
            pick_size <= '0;
            acc       <= '0;
            if (ram_we) begin
              used_map[SLOT_BITS'(req.block_slot)] <= 1'b0;
            end
            if (req.func == FUNC_CLEAR) begin
              used_map <= '0;
            end
            state <= (cfg.lim == '0) ? ST_COMMIT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (ram_re) begin
            issue_idx <= issue_idx + COUNT_BITS'(1);
          end
          chk_valid <= ram_re;
          chk_idx   <= ram_raddr;
          if (chk_valid) begin
            if (slot_free) begin
              acc <= acc + SUM_BITS'(ram_rdata);
            end
            if (take) begin
              found     <= 1'b1;
              pick_idx  <= chk_idx;
              pick_size <= ram_rdata;
            end
            if (last_chk) begin
              state <= ST_COMMIT;
            end
          end
        end
        ST_COMMIT: begin
          if (out_free) begin
            rsp.valid        <= 1'b1;
            rsp.granted      <= found;
            rsp.chosen_block <= found ? SLOT_W'(pick_idx) : '0;
            rsp.leftover     <= found ? LEFT_W'(pick_size - size_q) : '0;
            if (total_after > SUM_BITS'(TOTAL_MAX)) begin
              rsp.unfilled_total <= TOTAL_MAX;
            end else begin
              rsp.unfilled_total <= TOTAL_W'(total_after);
            end
            if (found) begin
              used_map[pick_idx] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `FPFA_ASSERT_IMP(a_pick_in_range, (state == ST_COMMIT) && found, COUNT_BITS'(pick_idx) < cfg.lim)
  `FPFA_ASSERT_IMP(a_no_underflow, (state == ST_COMMIT) && found, pick_size >= size_q)
  `FPFA_ASSERT_IMP(a_check_in_range, chk_valid, COUNT_BITS'(chk_idx) < cfg.lim)
  `FPFA_ASSERT_NEXT(a_grant_marks, (state == ST_COMMIT) && out_free && found, used_map[$past(pick_idx)])

endmodule

@@ hdl/fpfa_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module fpfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/fpfa_cfg.sv @@
// APB register block: fit policy and active slot count
module fpfa_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fpfa_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [fpfa_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [fpfa_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output fpfa_pkg::cfg_t                   cfg
);
  import fpfa_pkg::*;

  logic [POLICY_W-1:0] fit_policy;
  logic [BCOUNT_W-1:0] block_count;
  logic                wr_en;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // register writes; low address bits ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= POLICY_FIRST;
      block_count <= BCOUNT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_POLICY: fit_policy  <= pwdata[POLICY_W-1:0];
        REG_COUNT:  block_count <= pwdata[BCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      REG_POLICY: prdata = APB_DATA_W'(fit_policy);
      REG_COUNT:  prdata = APB_DATA_W'(block_count);
      default:    prdata = '0;
    endcase
  end

  // clamp the count to the slots that exist
  always_comb begin
    cfg.policy = fit_policy;
    if (32'(block_count) > NUM_SLOTS) begin
      cfg.lim = COUNT_BITS'(NUM_SLOTS);
    end else begin
      cfg.lim = COUNT_BITS'(block_count);
    end
  end

endmodule
